FILE: sv/paik_pkg.sv
// Shared constants, tables and types of the planar arm inverse kinematics unit.
`default_nettype none
package paik_pkg;

  localparam int LW           = 14;  // link length register width
  localparam int CFG_IDX_W    = 2;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int SQRT_STEPS   = 31;  // radicand below 2^62, one root bit per cell
  localparam int STEP_W       = 5;
  localparam int CW           = 60;  // CORDIC datapath width
  localparam int ZW           = 26;  // angle width, 2^-16 degree units
  localparam int SW           = 62;  // square root datapath width

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_LINK  = 2'd2;

  localparam logic [LW-1:0] FIRST_LINK_RESET  = 14'd1720;
  localparam logic [LW-1:0] SECOND_LINK_RESET = 14'd1475;
  localparam logic [LW-1:0] THIRD_LINK_RESET  = 14'd2294;

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic signed [CW-1:0] HALF_Q30 = 60'sd536870912;
  localparam logic signed [ZW-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [15:0] TOOL_LIMIT = 16'sd23040;

  localparam logic [22:0] ATAN_TAB [ATAN_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  typedef enum logic [1:0] {Q_NONE, Q_POS, Q_NEG} quarter_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] root;
  } sqrt_t;

  // Side data that rides along the rotation cells.
  typedef struct packed {
    logic signed [15:0]   x;
    logic signed [15:0]   y;
    logic signed [ZW-1:0] ang;
    quarter_t             q;
  } rot_side_t;

  // Side data that rides along the square root cells.
  typedef struct packed {
    logic                 unr;
    logic signed [18:0]   bx;
    logic signed [18:0]   by;
    logic signed [32:0]   nb;
    logic signed [32:0]   ng;
    logic signed [ZW-1:0] ang;
  } sqrt_side_t;

  // Side data that rides along the angle cells.
  typedef struct packed {
    logic                 unr;
    logic signed [ZW-1:0] ang;
    logic [2:0]           zero;
  } vec_side_t;

endpackage
`default_nettype wire

FILE: sv/planar_arm_inverse_kinematics_unit.sv
// Top level of the planar arm inverse kinematics unit.
//
// Input words on s_* carry a tool point and tool angle; one result word per input
// comes out on m_*, in order. m_tuser is the reachable flag; when it is low all
// three servo angles are zero. The user must write link lengths through cfg_we/
// cfg_index/cfg_data only while no word is in flight; the block does not enforce it.
// The datapath is a row of cells: a setup stage, 16 rotation CORDIC cells, four
// arithmetic stages (wrist point, squared distance, cosine-law terms, radicands),
// 31 square root digit cells, a setup stage, 16 vectoring CORDIC cells (three
// lanes side by side) and the output register.
// A new word is accepted every cycle while s_tready is high. The whole row
// advances together; a two-entry output buffer keeps s_tready high after
// m_tready drops until a result word fills its skid entry, then the row holds.
// Reset clears all valid flags and restores the default link lengths.
`default_nettype none
module planar_arm_inverse_kinematics_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire  [47:0]                    s_tdata,   // target_x, target_y, tool_angle
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [55:0]                    m_tdata,   // wrist, elbow, shoulder servo angle
  output logic                           m_tuser,   // reachable
  input  wire                            cfg_we,
  input  wire  [paik_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [paik_pkg::LW-1:0]        cfg_data
);
  import paik_pkg::*;

  function automatic logic signed [CW-1:0] lift(input logic signed [34:0] v);
    lift = {v[34], v, 24'b0};
  endfunction

  function automatic cordic_t prerot(input logic signed [34:0] xi,
                                     input logic signed [34:0] yi);
    cordic_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = lift(xi);
    ys = lift(yi);
    if (xi < 0) begin
      if (yi >= 0) begin
        r.x = ys;  r.y = -xs; r.z = DEG90;
      end else begin
        r.x = -ys; r.y = xs;  r.z = -DEG90;
      end
    end else begin
      r.x = xs; r.y = ys; r.z = '0;
    end
    prerot = r;
  endfunction

  logic [LW-1:0] l1, l2, l3;
  logic          en;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= FIRST_LINK_RESET;
      l2 <= SECOND_LINK_RESET;
      l3 <= THIRD_LINK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_LINK:  l1 <= cfg_data;
        REG_SECOND_LINK: l2 <= cfg_data;
        REG_THIRD_LINK:  l3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- setup stage
  logic signed [15:0]   t_in, t_cl;
  logic                 a_v;
  logic signed [15:0]   a_x, a_y;
  logic signed [ZW-1:0] a_ang;
  logic [43:0]          a_mag;

  always_comb begin
    t_in = s_tdata[47:32];
    if (t_in > TOOL_LIMIT)       t_cl = TOOL_LIMIT;
    else if (t_in < -TOOL_LIMIT) t_cl = -TOOL_LIMIT;
    else                         t_cl = t_in;
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x   <= s_tdata[15:0];
      a_y   <= s_tdata[31:16];
      a_ang <= {t_cl[15], t_cl, 9'b0};
      a_mag <= 44'(l3) * 44'(GAIN_Q30);
    end
  end

  // ---------------- rotation cells
  cordic_t   rot_c [CORDIC_STEPS+1];
  rot_side_t rot_s [CORDIC_STEPS+1];
  logic      rot_v [CORDIC_STEPS+1];

  always_comb begin
    rot_c[0].x = {16'b0, a_mag};
    rot_c[0].y = '0;
    rot_s[0].x = a_x;
    rot_s[0].y = a_y;
    rot_s[0].ang = a_ang;
    if (a_ang > DEG90) begin
      rot_c[0].z = a_ang - DEG90;
      rot_s[0].q = Q_POS;
    end else if (a_ang < -DEG90) begin
      rot_c[0].z = a_ang + DEG90;
      rot_s[0].q = Q_NEG;
    end else begin
      rot_c[0].z = a_ang;
      rot_s[0].q = Q_NONE;
    end
  end
  assign rot_v[0] = a_v;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    paik_cordic_cell u_cell (
      .clk(clk), .en(en), .vector_mode(1'b0), .step(STEP_W'(i)),
      .din(rot_c[i]), .dout(rot_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) rot_s[i+1] <= rot_s[i];
    end
    always_ff @(posedge clk) begin
      if (rst) rot_v[i+1] <= 1'b0;
      else if (en) rot_v[i+1] <= rot_v[i];
    end
  end

  // ---------------- wrist point
  logic signed [CW-1:0] rc, rs, rcr, rsr;
  logic                 b_v;
  logic signed [18:0]   b_bx, b_by;
  logic signed [ZW-1:0] b_ang;

  always_comb begin
    case (rot_s[CORDIC_STEPS].q)
      Q_POS:   begin rc = -rot_c[CORDIC_STEPS].y; rs = rot_c[CORDIC_STEPS].x;  end
      Q_NEG:   begin rc = rot_c[CORDIC_STEPS].y;  rs = -rot_c[CORDIC_STEPS].x; end
      default: begin rc = rot_c[CORDIC_STEPS].x;  rs = rot_c[CORDIC_STEPS].y;  end
    endcase
    rcr = (rc + HALF_Q30) >>> 30;
    rsr = (rs + HALF_Q30) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= rot_v[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_bx  <= 19'(rot_s[CORDIC_STEPS].x) - rcr[18:0];
      b_by  <= 19'(rot_s[CORDIC_STEPS].y) - rsr[18:0];
      b_ang <= rot_s[CORDIC_STEPS].ang;
    end
  end

  // ---------------- squared distance and link products
  logic signed [37:0]   sqx, sqy;
  logic [14:0]          lsum;
  logic [13:0]          ldif;
  logic                 c_v;
  logic [33:0]          c_lp;
  logic [29:0]          c_sumsq;
  logic [27:0]          c_difsq, c_l1sq, c_l2sq;
  logic [28:0]          c_m;
  logic signed [18:0]   c_bx, c_by;
  logic signed [ZW-1:0] c_ang;

  always_comb begin
    sqx  = b_bx * b_bx;
    sqy  = b_by * b_by;
    lsum = 15'(l1) + 15'(l2);
    ldif = (l1 > l2) ? l1 - l2 : l2 - l1;
  end

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lp    <= sqx[33:0] + sqy[33:0];
      c_sumsq <= 30'(lsum) * 30'(lsum);
      c_difsq <= 28'(ldif) * 28'(ldif);
      c_l1sq  <= 28'(l1) * 28'(l1);
      c_l2sq  <= 28'(l2) * 28'(l2);
      c_m     <= {28'(l1) * 28'(l2), 1'b0};
      c_bx    <= b_bx;
      c_by    <= b_by;
      c_ang   <= b_ang;
    end
  end

  // ---------------- reach test and cosine-law terms
  logic                 d_v, d_unr;
  logic signed [32:0]   d_nb, d_ng;
  logic [57:0]          d_p, d_msq;
  logic signed [18:0]   d_bx, d_by;
  logic signed [ZW-1:0] d_ang;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= c_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_unr <= (c_lp == '0) || (c_lp > {4'b0, c_sumsq}) || (c_lp < {6'b0, c_difsq});
      d_nb  <= signed'({5'b0, c_l1sq}) + signed'({3'b0, c_lp[29:0]})
               - signed'({5'b0, c_l2sq});
      d_ng  <= signed'({5'b0, c_l1sq}) + signed'({5'b0, c_l2sq})
               - signed'({3'b0, c_lp[29:0]});
      d_p   <= 58'(c_l1sq) * 58'(c_lp[29:0]);
      d_msq <= 58'(c_m) * 58'(c_m);
      d_bx  <= c_bx;
      d_by  <= c_by;
      d_ang <= c_ang;
    end
  end

  // ---------------- radicands
  logic signed [65:0] nbsq, ngsq, tb, tg;
  logic               e_v;
  sqrt_t              sb_c [SQRT_STEPS+1];
  sqrt_t              sg_c [SQRT_STEPS+1];
  sqrt_side_t         sq_s [SQRT_STEPS+1];
  logic               sq_v [SQRT_STEPS+1];

  always_comb begin
    nbsq = d_nb * d_nb;
    ngsq = d_ng * d_ng;
    tb   = signed'({6'b0, d_p, 2'b0}) - nbsq;
    tg   = signed'({8'b0, d_msq}) - ngsq;
  end

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= d_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A negative radicand counts as zero.
      sb_c[0].rem  <= (tb > 0) ? tb[SW-1:0] : '0;
      sb_c[0].root <= '0;
      sg_c[0].rem  <= (tg > 0) ? tg[SW-1:0] : '0;
      sg_c[0].root <= '0;
      sq_s[0]      <= '{unr: d_unr, bx: d_bx, by: d_by, nb: d_nb, ng: d_ng, ang: d_ang};
    end
  end
  assign sq_v[0] = e_v;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    paik_sqrt_cell u_sb (
      .clk(clk), .en(en), .step(STEP_W'(SQRT_STEPS-1-i)),
      .din(sb_c[i]), .dout(sb_c[i+1])
    );
    paik_sqrt_cell u_sg (
      .clk(clk), .en(en), .step(STEP_W'(SQRT_STEPS-1-i)),
      .din(sg_c[i]), .dout(sg_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) sq_s[i+1] <= sq_s[i];
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[i+1] <= 1'b0;
      else if (en) sq_v[i+1] <= sq_v[i];
    end
  end

  // ---------------- angle lanes: alpha, beta, gamma
  sqrt_side_t         sqe;
  logic signed [34:0] ax, ay, bxv, byv, gx, gy;
  cordic_t            va_c [CORDIC_STEPS+1];
  cordic_t            vb_c [CORDIC_STEPS+1];
  cordic_t            vg_c [CORDIC_STEPS+1];
  vec_side_t          vs   [CORDIC_STEPS+1];
  logic               vv   [CORDIC_STEPS+1];
  logic               f_v;

  always_comb begin
    sqe = sq_s[SQRT_STEPS];
    ax  = 35'(sqe.bx);
    ay  = 35'(sqe.by);
    bxv = 35'(sqe.nb);
    byv = signed'({5'b0, sb_c[SQRT_STEPS].root[29:0]});
    gx  = 35'(sqe.ng);
    gy  = signed'({5'b0, sg_c[SQRT_STEPS].root[29:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va_c[0] <= prerot(ax, ay);
      vb_c[0] <= prerot(bxv, byv);
      vg_c[0] <= prerot(gx, gy);
      vs[0]   <= '{unr: sqe.unr, ang: sqe.ang,
                   zero: {(gx == 0) && (gy == 0), (bxv == 0) && (byv == 0),
                          (ax == 0) && (ay == 0)}};
    end
  end
  assign vv[0] = f_v;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    paik_cordic_cell u_a (
      .clk(clk), .en(en), .vector_mode(1'b1), .step(STEP_W'(i)),
      .din(va_c[i]), .dout(va_c[i+1])
    );
    paik_cordic_cell u_b (
      .clk(clk), .en(en), .vector_mode(1'b1), .step(STEP_W'(i)),
      .din(vb_c[i]), .dout(vb_c[i+1])
    );
    paik_cordic_cell u_g (
      .clk(clk), .en(en), .vector_mode(1'b1), .step(STEP_W'(i)),
      .din(vg_c[i]), .dout(vg_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) vs[i+1] <= vs[i];
    end
    always_ff @(posedge clk) begin
      if (rst) vv[i+1] <= 1'b0;
      else if (en) vv[i+1] <= vv[i];
    end
  end

  // ---------------- joint angles and rounding
  vec_side_t            vse;
  logic signed [ZW-1:0] alpha, beta, gamma;
  logic signed [27:0]   th0, th1, wr, wr_r, el_r, sh_r;
  logic [55:0]          res_data;
  logic                 res_user;
  logic                 fin_v;

  always_comb begin
    vse   = vs[CORDIC_STEPS];
    fin_v = vv[CORDIC_STEPS];
    alpha = vse.zero[0] ? '0 : va_c[CORDIC_STEPS].z;
    beta  = vse.zero[1] ? '0 : vb_c[CORDIC_STEPS].z;
    gamma = vse.zero[2] ? '0 : vg_c[CORDIC_STEPS].z;
    if (alpha > DEG180)       alpha = DEG180;
    else if (alpha < -DEG180) alpha = -DEG180;
    if (beta > DEG180)        beta = DEG180;
    else if (beta < 0)        beta = '0;
    if (gamma > DEG180)       gamma = DEG180;
    else if (gamma < 0)       gamma = '0;
    th0  = 28'(alpha) + 28'(beta) - 28'(DEG90);
    th1  = 28'(gamma) - 28'(DEG180);
    wr   = th0 + th1 + 28'(DEG90) - 28'(vse.ang);
    wr_r = wr + 28'sd256;
    el_r = 28'sd256 - th1;
    sh_r = th0 + 28'sd256;
    if (vse.unr) begin
      res_data = '0;
      res_user = 1'b0;
    end else begin
      res_data = {6'b0, sh_r[25:9], el_r[23:9], wr_r[26:9]};
      res_user = 1'b1;
    end
  end

  // ---------------- output register with one skid entry
  logic        skid_v;
  logic [55:0] skid_data;
  logic        skid_user;
  logic        out_load;

  assign en       = !skid_v;
  assign s_tready = en;
  assign out_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= skid_v || fin_v;
      skid_v   <= 1'b0;
    end else if (fin_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= skid_v ? skid_data : res_data;
      m_tuser <= skid_v ? skid_user : res_user;
    end else if (fin_v && en) begin
      skid_data <= res_data;
      skid_user <= res_user;
    end
  end

endmodule
`default_nettype wire

FILE: sv/paik_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered output.
`default_nettype none
module paik_cordic_cell (
  input  wire                      clk,
  input  wire                      en,
  input  wire                      vector_mode,
  input  wire [paik_pkg::STEP_W-1:0] step,
  input  paik_pkg::cordic_t        din,
  output paik_pkg::cordic_t        dout
);
  import paik_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] at;
  logic                 up;
  cordic_t              nxt;

  always_comb begin
    dx = din.x >>> step;
    dy = din.y >>> step;
    at = signed'({3'b000, ATAN_TAB[step]});
    // Vectoring drives y toward zero, rotation drives z toward zero.
    up = vector_mode ? !(din.y > 0) : (din.z >= 0);
    if (up) begin
      nxt.x = din.x - dy;
      nxt.y = din.y + dx;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + dy;
      nxt.y = din.y - dx;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/paik_sqrt_cell.sv
// One digit cell of the floor square root, one root bit per cell.
`default_nettype none
module paik_sqrt_cell (
  input  wire                        clk,
  input  wire                        en,
  input  wire [paik_pkg::STEP_W-1:0] step,
  input  paik_pkg::sqrt_t            din,
  output paik_pkg::sqrt_t            dout
);
  import paik_pkg::*;

  logic [SW-1:0] bitv;
  logic [SW-1:0] trial;
  sqrt_t         nxt;

  always_comb begin
    bitv  = {{(SW-1){1'b0}}, 1'b1} << {step, 1'b0};
    trial = din.root + bitv;
    if (din.rem >= trial) begin
      nxt.rem  = din.rem - trial;
      nxt.root = (din.root >> 1) + bitv;
    end else begin
      nxt.rem  = din.rem;
      nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/paik_checker.sv
// Port-level checks of the planar arm inverse kinematics unit, bound to the top level.
`default_nettype none
module paik_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [55:0] m_tdata,
  input wire        m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not empty or input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 56'd0)
    else $error("unreachable word carries nonzero angles");

  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[32:18] <= 15'd23040)
    else $error("elbow angle above 180 degrees");

endmodule

bind planar_arm_inverse_kinematics_unit paik_checker u_paik_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
